>>> rtl/imadec_pkg.sv
`timescale 1ns / 1ps
// imadec_pkg: shared types, register map and tables of the ima adpcm decoder
// no dependencies

package imadec_pkg;

    localparam int PCM_W      = 16;
    localparam int IDX_W      = 7;
    localparam int OUT_W      = 8;
    localparam int IDX_MAX    = 88;
    localparam int PADDR_W    = 4;
    localparam int SUM_W      = 19;

    typedef enum logic [1:0] {
        REG_DITHER_EN = 2'd0,
        REG_ROUND_EN  = 2'd1,
        REG_SEED      = 2'd2
    } reg_idx_t;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_CODE  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic        dither_enable;
        logic        round_enable;
        logic        seed_load;
        logic [31:0] seed;
    } cfg_t;

    typedef struct packed {
        logic signed [PCM_W-1:0] predictor;
        logic [IDX_W-1:0]        step_index;
    } dec_state_t;

    function automatic logic [15:0] step_lookup(input logic [IDX_W-1:0] idx);
        logic [15:0] tab [0:IDX_MAX];
        tab = '{
            16'd7, 16'd8, 16'd9, 16'd10, 16'd11, 16'd12, 16'd13, 16'd14, 16'd16,
            16'd17, 16'd19, 16'd21, 16'd23, 16'd25, 16'd28, 16'd31, 16'd34, 16'd37,
            16'd41, 16'd45, 16'd50, 16'd55, 16'd60, 16'd66, 16'd73, 16'd80, 16'd88,
            16'd97, 16'd107, 16'd118, 16'd130, 16'd143, 16'd157, 16'd173, 16'd190,
            16'd209, 16'd230, 16'd253, 16'd279, 16'd307, 16'd337, 16'd371, 16'd408,
            16'd449, 16'd494, 16'd544, 16'd598, 16'd658, 16'd724, 16'd796, 16'd876,
            16'd963, 16'd1060, 16'd1166, 16'd1282, 16'd1411, 16'd1552, 16'd1707,
            16'd1878, 16'd2066, 16'd2272, 16'd2499, 16'd2749, 16'd3024, 16'd3327,
            16'd3660, 16'd4026, 16'd4428, 16'd4871, 16'd5358, 16'd5894, 16'd6484,
            16'd7132, 16'd7845, 16'd8630, 16'd9493, 16'd10442, 16'd11487, 16'd12635,
            16'd13899, 16'd15289, 16'd16818, 16'd18500, 16'd20350, 16'd22385,
            16'd24623, 16'd27086, 16'd29794, 16'd32767
        };
        if (idx > IDX_W'(IDX_MAX)) begin
            return 16'd32767;
        end
        return tab[idx];
    endfunction

    function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
        logic signed [4:0] adj;
        unique case (mag)
            3'd4:    adj = 5'sd2;
            3'd5:    adj = 5'sd4;
            3'd6:    adj = 5'sd6;
            3'd7:    adj = 5'sd8;
            default: adj = -5'sd1;
        endcase
        return adj;
    endfunction

endpackage

>>> rtl/imadec_cfg.sv
`timescale 1ns / 1ps
// imadec_cfg: apb configuration registers of the ima adpcm decoder
// depends on imadec_pkg

module imadec_cfg
    import imadec_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic        dither_en_reg;
    logic        round_en_reg;
    logic [31:0] seed_reg;
    logic        wr_en;
    reg_idx_t    wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dither_en_reg <= 1'b1;
            round_en_reg  <= 1'b0;
            seed_reg      <= 32'd1;
        end else if (wr_en) begin
            unique case (wr_idx)
                REG_DITHER_EN: dither_en_reg <= pwdata[0];
                REG_ROUND_EN:  round_en_reg  <= pwdata[0];
                REG_SEED:      seed_reg      <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (wr_idx)
            REG_DITHER_EN: prdata = {31'd0, dither_en_reg};
            REG_ROUND_EN:  prdata = {31'd0, round_en_reg};
            REG_SEED:      prdata = seed_reg;
            default:       prdata = 32'd0;
        endcase
    end

    // seed write reloads the generator in the same edge
    assign cfg.dither_enable = dither_en_reg;
    assign cfg.round_enable  = round_en_reg;
    assign cfg.seed_load     = wr_en && (wr_idx == REG_SEED);
    assign cfg.seed          = pwdata;

    a_pready_high: assert property (@(posedge aclk) pready)
        else $error("pready dropped");

    a_seed_flag: assert property (@(posedge aclk)
        cfg.seed_load |-> wr_en && (wr_idx == REG_SEED))
        else $error("seed load without a seed write");

    a_seed_value: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.seed_load |=> seed_reg == $past(pwdata))
        else $error("seed register not written");

endmodule

>>> rtl/imadec_dp.sv
`timescale 1ns / 1ps
// imadec_dp: one decode step (start load or one nibble), dither and 8-bit output
// depends on imadec_pkg

module imadec_dp
    import imadec_pkg::*;
#(
    parameter int DITHER_SHIFT = 24
)
(
    input  logic                           is_start,
    input  logic signed [PCM_W-1:0]        start_sample,
    input  logic [IDX_W-1:0]               start_index,
    input  logic [3:0]                     nibble,
    input  dec_state_t                     state_cur,
    input  logic [31-DITHER_SHIFT:0]       dither_prev,
    input  logic [31:0]                    dither_gen,
    input  logic                           dither_enable,
    input  logic                           round_enable,
    output dec_state_t                     state_next,
    output logic [31-DITHER_SHIFT:0]       dither_prev_next,
    output logic [31:0]                    dither_gen_next,
    output logic signed [OUT_W-1:0]        pcm
);

    localparam int DW = 32 - DITHER_SHIFT;

    logic [15:0]             step;
    logic [16:0]             delta;
    logic [2:0]              mag;
    logic signed [SUM_W-1:0] pred_sum;
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] dith;
    logic signed [SUM_W-1:0] total;
    logic signed [PCM_W-1:0] clamped;
    logic [DW-1:0]           cur;
    logic signed [8:0]       idx_sum;
    logic [IDX_W-1:0]        idx_code;
    logic [IDX_W-1:0]        idx_new;
    logic signed [PCM_W:0]   rnd;
    logic signed [8:0]       rnd_hi;

    assign mag  = nibble[2:0];
    assign step = step_lookup(state_cur.step_index);

    // shift-add form of the ima delta
    always_comb begin
        delta = 17'(step >> 3);
        if (mag[2]) delta = delta + 17'(step);
        if (mag[1]) delta = delta + 17'(step >> 1);
        if (mag[0]) delta = delta + 17'(step >> 2);
    end

    always_comb begin
        if (nibble[3]) begin
            pred_sum = SUM_W'(state_cur.predictor) - $signed({2'b00, delta});
        end else begin
            pred_sum = SUM_W'(state_cur.predictor) + $signed({2'b00, delta});
        end
    end

    // step index update
    assign idx_sum = $signed({2'b00, state_cur.step_index}) + 9'(index_adjust(mag));
    always_comb begin
        if (idx_sum < 9'sd0) begin
            idx_code = '0;
        end else if (idx_sum > 9'sd88) begin
            idx_code = IDX_W'(IDX_MAX);
        end else begin
            idx_code = idx_sum[IDX_W-1:0];
        end
    end

    assign idx_new = (start_index > IDX_W'(IDX_MAX)) ? IDX_W'(IDX_MAX) : start_index;

    // high-pass dither
    assign cur = dither_gen[31:DITHER_SHIFT];
    always_comb begin
        if (dither_enable) begin
            dith             = SUM_W'($signed({1'b0, cur})) - SUM_W'($signed({1'b0, dither_prev}));
            dither_prev_next = cur;
            dither_gen_next  = ((dither_gen << 4) - dither_gen) ^ 32'd1;
        end else begin
            dith             = '0;
            dither_prev_next = dither_prev;
            dither_gen_next  = dither_gen;
        end
    end

    assign base  = is_start ? SUM_W'(start_sample) : pred_sum;
    assign total = base + dith;

    always_comb begin
        if (total < -SUM_W'(32768)) begin
            clamped = PCM_W'(-32768);
        end else if (total > SUM_W'(32767)) begin
            clamped = PCM_W'(32767);
        end else begin
            clamped = total[PCM_W-1:0];
        end
    end

    assign state_next.predictor  = clamped;
    assign state_next.step_index = is_start ? idx_new : idx_code;

    // 8-bit output, rounding saturates at the top
    assign rnd    = (PCM_W+1)'(clamped) + (PCM_W+1)'(128);
    assign rnd_hi = rnd[PCM_W:8];
    always_comb begin
        if (!round_enable) begin
            pcm = clamped[PCM_W-1:8];
        end else if (rnd_hi > 9'sd127) begin
            pcm = 8'sd127;
        end else begin
            pcm = rnd_hi[OUT_W-1:0];
        end
    end

endmodule

>>> rtl/ima_adpcm_decoder_dithered.sv
`timescale 1ns / 1ps
// ima_adpcm_decoder_dithered: top level, item register, decoder state, result register
// depends on imadec_pkg, imadec_cfg, imadec_dp
//
//  channel  dir  width  contents
//  s_*      in   32+1+1 start sample/index or code byte, tuser command, tlast last byte
//  m_*      out  8+1    pcm sample, tlast on final result of an item
//  apb      in   4/32   dither_enable @0x0, round_enable @0x4, dither_seed @0x8
//
// a start item is one decode step, a code byte one step per nibble (two, or one if tlast)
// the nibble chain through predictor and step index runs from state_reg back to state_reg
// a new item is taken in the cycle its predecessor's last result is loaded into the result register
// m_tready low while a result is held holds the result register and stalls decoding; s_tready follows
// reset is synchronous, active low, with no clearing pass

module ima_adpcm_decoder_dithered
    import imadec_pkg::*;
#(
    parameter int DITHER_SHIFT = 24
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // start_sample[15:0], start_index[22:16], code_byte[30:23]
    input  logic               s_tuser,   // command[0]
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // pcm_out[7:0]
    output logic               m_tlast,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int DW = 32 - DITHER_SHIFT;

    cfg_t cfg;

    logic                    item_valid_reg;
    cmd_t                    cmd_reg;
    logic signed [PCM_W-1:0] sample_reg;
    logic [IDX_W-1:0]        index_reg;
    logic [7:0]              byte_reg;
    logic                    last_reg;
    logic                    phase_reg;

    dec_state_t              state_reg;
    dec_state_t              state_next;
    logic [DW-1:0]           dprev_reg;
    logic [DW-1:0]           dprev_next;
    logic [31:0]             gen_reg;
    logic [31:0]             gen_next;

    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_data_reg;
    logic                    out_last_reg;

    logic                    fire;
    logic                    final_step;
    logic                    s_xfer;
    logic [3:0]              nibble;
    logic signed [OUT_W-1:0] pcm;

    imadec_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign nibble = phase_reg ? byte_reg[7:4] : byte_reg[3:0];

    imadec_dp #(
        .DITHER_SHIFT (DITHER_SHIFT)
    ) u_dp (
        .is_start         (cmd_reg == CMD_START),
        .start_sample     (sample_reg),
        .start_index      (index_reg),
        .nibble           (nibble),
        .state_cur        (state_reg),
        .dither_prev      (dprev_reg),
        .dither_gen       (gen_reg),
        .dither_enable    (cfg.dither_enable),
        .round_enable     (cfg.round_enable),
        .state_next       (state_next),
        .dither_prev_next (dprev_next),
        .dither_gen_next  (gen_next),
        .pcm              (pcm)
    );

    assign fire       = item_valid_reg && (!out_valid_reg || m_tready);
    assign final_step = (cmd_reg == CMD_START) || last_reg || phase_reg;
    assign s_tready   = !item_valid_reg || (fire && final_step);
    assign s_xfer     = s_tvalid && s_tready;

    // item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end else if (s_xfer) begin
            item_valid_reg <= 1'b1;
            phase_reg      <= 1'b0;
        end else if (fire) begin
            item_valid_reg <= !final_step;
            phase_reg      <= !final_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            cmd_reg    <= cmd_t'(s_tuser);
            sample_reg <= $signed(s_tdata[15:0]);
            index_reg  <= s_tdata[22:16];
            byte_reg   <= s_tdata[30:23];
            last_reg   <= s_tlast;
        end
    end

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            dprev_reg <= '0;
        end else if (fire) begin
            state_reg <= state_next;
            dprev_reg <= dprev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg <= 32'd1;
        end else if (cfg.seed_load) begin
            gen_reg <= cfg.seed;
        end else if (fire) begin
            gen_reg <= gen_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= pcm;
            out_last_reg <= final_step;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.step_index <= IDX_W'(IDX_MAX))
        else $error("step index out of range");

    a_phase_item: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> item_valid_reg && (cmd_reg == CMD_CODE) && !last_reg)
        else $error("high nibble pending without a two-nibble code byte");

    a_first_nibble: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !final_step |=> item_valid_reg && phase_reg && out_valid_reg)
        else $error("high nibble lost after low nibble");

    a_open_run: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_last_reg |-> item_valid_reg && phase_reg)
        else $error("non-final result without a pending nibble");

endmodule

>>> verif/imadec_checker.sv
`timescale 1ns / 1ps
// imadec_checker: watches the stream and register ports of the ima adpcm decoder,
// predicts every pcm result and compares it with the observed result transfers
// depends on imadec_pkg

module imadec_checker
    import imadec_pkg::*;
#(
    parameter int DITHER_SHIFT = 24
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [31:0]        s_tdata,   // start_sample[15:0], start_index[22:16], code_byte[30:23]
    input  logic               s_tuser,   // command[0]
    input  logic               s_tlast,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [7:0]         m_tdata,   // pcm_out[7:0]
    input  logic               m_tlast,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output int                 errors,
    output int                 pending
);

    localparam int DW = 32 - DITHER_SHIFT;

    typedef struct packed {
        logic [OUT_W-1:0] pcm;
        logic             last;
    } pcm_result_t;

    int step_size [0:IDX_MAX];

    logic signed [PCM_W-1:0] pred_q;
    logic [IDX_W-1:0]        index_q;
    logic [DW-1:0]           dith_prev;
    logic [31:0]             dith_gen;
    logic                    cfg_dither;
    logic                    cfg_round;
    pcm_result_t             pcm_expected [$];
    pcm_result_t             got;
    pcm_result_t             want;
    int                      start_val;

    initial begin
        step_size = '{
            7, 8, 9, 10, 11, 12, 13, 14, 16, 17, 19, 21, 23, 25, 28, 31, 34, 37, 41,
            45, 50, 55, 60, 66, 73, 80, 88, 97, 107, 118, 130, 143, 157, 173, 190,
            209, 230, 253, 279, 307, 337, 371, 408, 449, 494, 544, 598, 658, 724,
            796, 876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066, 2272,
            2499, 2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358, 5894, 6484, 7132,
            7845, 8630, 9493, 10442, 11487, 12635, 13899, 15289, 16818, 18500,
            20350, 22385, 24623, 27086, 29794, 32767
        };
    end

    function automatic int sat16(input int v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return v;
    endfunction

    // high-pass dither: new generator top bits minus the previous ones
    function automatic int apply_dither_step(input int p);
        int cur;
        int prev;
        cur = int'(dith_gen >> DITHER_SHIFT);
        prev = int'(dith_prev);
        dith_prev = cur[DW-1:0];
        dith_gen = (dith_gen * 32'd15) ^ 32'd1;
        return p + cur - prev;
    endfunction

    function automatic logic [OUT_W-1:0] to_pcm8(input int p);
        int r;
        if (cfg_round) begin
            r = (p + 128) >>> 8;
            if (r > 127) r = 127;
        end else begin
            r = p >>> 8;
        end
        return r[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] decode_nibble(input logic [3:0] nib);
        int step;
        int delta;
        int p;
        int idx;
        step = step_size[index_q];
        delta = step >> 3;
        if (nib[2]) delta += step;
        if (nib[1]) delta += step >> 1;
        if (nib[0]) delta += step >> 2;
        p = int'(pred_q);
        p = nib[3] ? p - delta : p + delta;
        idx = int'(index_q) + (nib[2] ? 2 * (int'(nib[1:0]) + 1) : -1);
        if (idx < 0) idx = 0;
        if (idx > IDX_MAX) idx = IDX_MAX;
        index_q = idx[IDX_W-1:0];
        if (cfg_dither) p = apply_dither_step(p);
        p = sat16(p);
        pred_q = p[PCM_W-1:0];
        return to_pcm8(p);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            pred_q     = '0;
            index_q    = '0;
            dith_prev  = '0;
            dith_gen   = 32'd1;
            cfg_dither = 1'b1;
            cfg_round  = 1'b0;
            pcm_expected.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[PADDR_W-1:2]))
                    REG_DITHER_EN: cfg_dither = pwdata[0];
                    REG_ROUND_EN:  cfg_round = pwdata[0];
                    REG_SEED:      dith_gen = pwdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (cmd_t'(s_tuser) == CMD_START) begin
                    start_val = int'($signed(s_tdata[15:0]));
                    if (cfg_dither) start_val = sat16(apply_dither_step(start_val));
                    pred_q = start_val[PCM_W-1:0];
                    index_q = (s_tdata[22:16] > IDX_W'(IDX_MAX)) ? IDX_W'(IDX_MAX)
                                                                 : s_tdata[22:16];
                    want.pcm = to_pcm8(start_val);
                    want.last = 1'b1;
                    pcm_expected.push_back(want);
                end else begin
                    want.pcm = decode_nibble(s_tdata[26:23]);
                    want.last = s_tlast;
                    pcm_expected.push_back(want);
                    if (!s_tlast) begin
                        want.pcm = decode_nibble(s_tdata[30:27]);
                        want.last = 1'b1;
                        pcm_expected.push_back(want);
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                got.pcm = m_tdata;
                got.last = m_tlast;
                if (pcm_expected.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got pcm_out %0d last %0b",
                             $time, $signed(got.pcm), got.last);
                end else begin
                    want = pcm_expected.pop_front();
                    if (got.pcm !== want.pcm) begin
                        errors++;
                        $display("%0t: pcm_out mismatch, expected %0d, got %0d",
                                 $time, $signed(want.pcm), $signed(got.pcm));
                    end
                    if (got.last !== want.last) begin
                        errors++;
                        $display("%0t: tlast mismatch, expected %0b, got %0b",
                                 $time, want.last, got.last);
                    end
                end
            end
        end
        pending <= pcm_expected.size();
    end

endmodule

>>> verif/tb_ima_adpcm_decoder_dithered.sv
`timescale 1ns / 1ps
// tb_ima_adpcm_decoder_dithered: stimulus, register writes and verdict for the decoder
// depends on imadec_pkg, imadec_checker and the decoder rtl

module tb_ima_adpcm_decoder_dithered;
    import imadec_pkg::*;

    localparam int SHIFT       = 24;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 200;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata = '0;
    logic               s_tuser = 1'b0;
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;
    logic               m_tlast;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int errors;
    int pending;
    int s_idle_pct = 0;
    int m_idle_pct = 0;
    int stall_cycles = 0;

    always #1 aclk = ~aclk;

    ima_adpcm_decoder_dithered #(.DITHER_SHIFT(SHIFT)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    imadec_checker #(.DITHER_SHIFT(SHIFT)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .errors(errors), .pending(pending)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [31:0] pack_item(input logic [15:0] sample,
                                              input logic [6:0] index,
                                              input logic [7:0] code);
        return {1'b0, code, index, sample};
    endfunction

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(input cmd_t cmd, input logic [31:0] fields, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < s_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= fields;
        s_tuser  <= cmd;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off the sender until every predicted sample has come back
    task automatic drain_results;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (6) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [6:0] pick_index();
        if ($urandom_range(0, 99) < 85) return 7'($urandom_range(0, IDX_MAX));
        return 7'($urandom_range(0, 127));
    endfunction

    // a channel block: start, then code bytes with tlast on the final one
    task automatic send_block(output int count);
        int n;
        n = $urandom_range(1, 12);
        send_item(CMD_START, pack_item(pick_sample(), pick_index(), 8'($urandom_range(0, 255))),
                  1'($urandom_range(0, 1)));
        for (int k = 0; k < n; k++) begin
            send_item(CMD_CODE, pack_item(16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)),
                      8'($urandom_range(0, 255))), k == n - 1);
        end
        count = n + 1;
    endtask

    // stray items: mostly code bytes, some starts, no leading start, random tlast
    task automatic send_noise(output int count);
        int n;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
            send_item(cmd_t'($urandom_range(0, 3) != 0), $urandom() & 32'h7FFF_FFFF,
                      1'($urandom_range(0, 1)));
        end
        count = n;
    endtask

    initial begin
        int sent;
        int cnt;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        s_idle_pct = 36;
        m_idle_pct = 81;

        // code bytes before any start, reset settings
        send_item(CMD_CODE, pack_item(16'h0, 7'd0, 8'h7F), 1'b0);
        send_item(CMD_CODE, pack_item(16'h0, 7'd0, 8'hF8), 1'b1);
        drain_results();

        apb_write(REG_DITHER_EN, 32'd0);
        apb_write(REG_ROUND_EN, 32'd0);
        send_item(CMD_START, pack_item(16'h7FFF, 7'd0, 8'h00), 1'b0);
        send_item(CMD_CODE, pack_item(16'h0, 7'd0, 8'h77), 1'b0);
        send_item(CMD_START, pack_item(16'h8000, 7'd127, 8'h00), 1'b1);
        send_item(CMD_CODE, pack_item(16'h0, 7'd0, 8'hFF), 1'b0);
        send_item(CMD_CODE, pack_item(16'h0, 7'd0, 8'h88), 1'b0);
        send_item(CMD_START, pack_item(16'h0000, 7'd89, 8'h00), 1'b0);
        send_item(CMD_CODE, pack_item(16'h0, 7'd0, 8'h00), 1'b0);
        send_item(CMD_CODE, pack_item(16'h0, 7'd0, 8'hF0), 1'b1);
        drain_results();

        // rounding near full scale saturates
        apb_write(REG_ROUND_EN, 32'd1);
        send_item(CMD_START, pack_item(16'h7FFF, 7'd88, 8'h00), 1'b0);
        send_item(CMD_START, pack_item(16'h7F80, 7'd60, 8'h00), 1'b0);
        send_item(CMD_CODE, pack_item(16'h0, 7'd0, 8'h77), 1'b0);
        send_item(CMD_START, pack_item(16'h8000, 7'd88, 8'h00), 1'b0);
        send_item(CMD_CODE, pack_item(16'h0, 7'd0, 8'hFF), 1'b1);
        drain_results();

        // start with dither, clamped, after seed loads
        apb_write(REG_DITHER_EN, 32'd1);
        apb_write(REG_SEED, 32'hFFFF_FFFF);
        send_item(CMD_START, pack_item(16'h7FFF, 7'd88, 8'h00), 1'b0);
        send_item(CMD_START, pack_item(16'h8000, 7'd0, 8'h00), 1'b0);
        send_item(CMD_CODE, pack_item(16'h0, 7'd0, 8'h9A), 1'b0);
        drain_results();
        apb_write(REG_SEED, 32'd0);
        send_item(CMD_START, pack_item(16'h0000, 7'd40, 8'h00), 1'b0);
        send_item(CMD_CODE, pack_item(16'h0, 7'd0, 8'h3C), 1'b0);

        for (int ph = 0; ph < 6; ph++) begin
            drain_results();
            s_idle_pct = (ph < 2) ? 36 : (ph < 4) ? 81 : 0;
            m_idle_pct = (ph < 2) ? 81 : (ph < 4) ? 36 : 0;
            apb_write(REG_DITHER_EN, (ph % 3 != 1) ? 32'd1 : 32'd0);
            apb_write(REG_ROUND_EN, 32'(ph % 2));
            apb_write(REG_SEED, (ph == 2) ? 32'hFFFF_FFFF : (ph == 4) ? 32'd0 : $urandom());
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 85) send_block(cnt);
                else send_noise(cnt);
                sent += cnt;
            end
        end

        drain_results();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/imadec_pkg.sv
rtl/imadec_cfg.sv
rtl/imadec_dp.sv
rtl/ima_adpcm_decoder_dithered.sv
verif/imadec_checker.sv
verif/tb_ima_adpcm_decoder_dithered.sv
